// File: design/tab_separated_request_line_parser_unit_macros.svh
// Assertion macros shared by the request line parser modules.
// Depends on nothing; each module that asserts includes this header.
`ifndef TAB_SEPARATED_REQUEST_LINE_PARSER_UNIT_MACROS_SVH
`define TAB_SEPARATED_REQUEST_LINE_PARSER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSRLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsrlp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSRLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsrlp assertion failed");

`endif

// File: design/tsrlp_pkg.sv
// Shared types, codes and constants of the request line parser.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package tsrlp_pkg;

    // Default values of the top level parameters.
    localparam int ID_WIDTH_DEFAULT       = 64;
    localparam int PENDING_BREAKS_DEFAULT = 4;
    localparam int MAX_ARGUMENTS_DEFAULT  = 255;
    localparam int QUEUE_DEPTH            = 4;

    // Special characters of the line format.
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Token kinds.
    localparam logic [1:0] KIND_CMD = 2'd0;
    localparam logic [1:0] KIND_KEY = 2'd1;
    localparam logic [1:0] KIND_VAL = 2'd2;
    localparam logic [1:0] KIND_END = 2'd3;

    // End status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_FEW     = 3'd1;
    localparam logic [2:0] ST_BAD_ID      = 3'd2;
    localparam logic [2:0] ST_BAD_CMD     = 3'd3;
    localparam logic [2:0] ST_NO_SEP      = 3'd4;
    localparam logic [2:0] ST_BAD_ENC     = 3'd5;
    localparam logic [2:0] ST_LONG_BREAK  = 3'd6;

    // Operations carried from the front end to the back end.
    typedef enum logic [1:0] {
        OP_BYTE,
        OP_ERR6,
        OP_EOL
    } tsrlp_op_t;

    // One queue entry; step_end marks the last entry of one input transfer.
    typedef struct packed {
        tsrlp_op_t  op;
        logic [7:0] data;
        logic       step_end;
    } tsrlp_entry_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       end_of_line;
    } tsrlp_in_t;

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [7:0]  decoded_byte;
        logic [7:0]  argument_number;
        logic [63:0] request_id;
        logic [2:0]  status;
        logic        last_result;
    } tsrlp_out_t;

    // Hex digit decode: bit 4 is set when the character is a hex digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

// File: design/tab_separated_request_line_parser_unit.sv
// Top level of the tab separated request line parser.
// Depends on tsrlp_pkg, tsrlp_front, tsrlp_queue and tsrlp_back.
//
//   Channel   Signals                          Moves
//   req       req_valid req_ready req_data     one raw line byte and its end flag
//   tok       tok_valid tok_ready tok_data     one decoded token or end status
//
// A byte after held CR/LF bytes is queued behind one entry per held byte and,
// when the run overflowed, an ERR6 entry; a plain byte that ends the line is
// followed by an EOL entry. The front end writes one queue entry per cycle
// while the queue has room; the back end retires one per cycle while its
// output is free, and a transfer whose final entry finds a token still held
// adds a flush step. Reset clears all control state at once; there is no clearing
// pass. Either side may stall: the queue and the output register decouple them.
`timescale 1ns / 1ps

module tab_separated_request_line_parser_unit #(
    parameter int ID_WIDTH       = tsrlp_pkg::ID_WIDTH_DEFAULT,
    parameter int PENDING_BREAKS = tsrlp_pkg::PENDING_BREAKS_DEFAULT,
    parameter int MAX_ARGUMENTS  = tsrlp_pkg::MAX_ARGUMENTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  tsrlp_pkg::tsrlp_in_t  req_data,
    output logic                  tok_valid,
    input  logic                  tok_ready,
    output tsrlp_pkg::tsrlp_out_t tok_data
);
    import tsrlp_pkg::*;

    logic         push_valid;
    logic         push_ready;
    tsrlp_entry_t push_data;
    logic         pop_valid;
    logic         pop_ready;
    tsrlp_entry_t pop_data;

    // Byte intake and break run handling.
    tsrlp_front #(
        .PENDING_BREAKS (PENDING_BREAKS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decoupling queue.
    tsrlp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Field parsing and result output.
    tsrlp_back #(
        .ID_WIDTH      (ID_WIDTH),
        .MAX_ARGUMENTS (MAX_ARGUMENTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (pop_valid),
        .entry_ready (pop_ready),
        .entry_data  (pop_data),
        .tok_valid   (tok_valid),
        .tok_ready   (tok_ready),
        .tok_data    (tok_data)
    );

endmodule

// File: design/tsrlp_queue.sv
// Short register queue between the front end and the back end.
// Depends on tsrlp_pkg for the entry type.
`timescale 1ns / 1ps

module tsrlp_queue #(
    parameter int DEPTH = tsrlp_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  tsrlp_pkg::tsrlp_entry_t push_data,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output tsrlp_pkg::tsrlp_entry_t pop_data
);
    import tsrlp_pkg::*;

    `include "tab_separated_request_line_parser_unit_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tsrlp_entry_t     slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    // Handshake on both sides.
    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    `TSRLP_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

// File: design/tsrlp_front.sv
// Front end: accepts line bytes, holds CR/LF runs and sequences queue entries.
// Depends on tsrlp_pkg for the transfer and entry types.
`timescale 1ns / 1ps

module tsrlp_front #(
    parameter int PENDING_BREAKS = tsrlp_pkg::PENDING_BREAKS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  tsrlp_pkg::tsrlp_in_t    req_data,
    output logic                    push_valid,
    input  logic                    push_ready,
    output tsrlp_pkg::tsrlp_entry_t push_data
);
    import tsrlp_pkg::*;

    `include "tab_separated_request_line_parser_unit_macros.svh"

    localparam int CNT_W = $clog2(PENDING_BREAKS + 1);
    localparam int IDX_W = (PENDING_BREAKS > 1) ? $clog2(PENDING_BREAKS) : 1;

    typedef enum logic [2:0] {
        F_IDLE,
        F_REPLAY,
        F_ERR6,
        F_BYTE,
        F_EOL
    } front_state_t;

    front_state_t     fstate_reg, fstate_next;
    logic             bits_reg [PENDING_BREAKS];
    logic             bits_next [PENDING_BREAKS];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       byte_reg, byte_next;
    logic             eol_reg, eol_next;
    logic             accept;
    logic             is_brk;

    assign is_brk    = (req_data.line_byte == CH_CR) || (req_data.line_byte == CH_LF);
    assign req_ready = (fstate_reg == F_IDLE) && push_ready;
    assign accept    = req_valid && req_ready;

    // Sequencer: replays held breaks, then the flag, the byte and the line end.
    always_comb
    begin
        fstate_next = fstate_reg;
        bits_next   = bits_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        idx_next    = idx_reg;
        byte_next   = byte_reg;
        eol_next    = eol_reg;
        push_valid  = 1'b0;
        push_data   = '{op: OP_BYTE, data: byte_reg, step_end: !eol_reg};

        unique case (fstate_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    byte_next = req_data.line_byte;
                    eol_next  = req_data.end_of_line;
                    if (is_brk && !req_data.end_of_line)
                    begin
                        // Hold the break; past the limit only note the overflow.
                        if (cnt_reg < CNT_W'(PENDING_BREAKS))
                        begin
                            bits_next[cnt_reg[IDX_W-1:0]] = (req_data.line_byte == CH_LF);
                            cnt_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if (is_brk)
                    begin
                        // A trailing break run is dropped.
                        push_valid = 1'b1;
                        push_data  = '{op: OP_EOL, data: 8'd0, step_end: 1'b1};
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                    end
                    else if (cnt_reg == '0)
                    begin
                        push_valid = 1'b1;
                        push_data  = '{op: OP_BYTE, data: req_data.line_byte,
                                       step_end: !req_data.end_of_line};
                        if (req_data.end_of_line)
                        begin
                            fstate_next = F_EOL;
                        end
                    end
                    else
                    begin
                        push_valid = 1'b1;
                        push_data  = '{op: OP_BYTE, data: bits_reg[0] ? CH_LF : CH_CR,
                                       step_end: 1'b0};
                        idx_next   = IDX_W'(1);
                        if (cnt_reg == CNT_W'(1))
                        begin
                            fstate_next = ovf_reg ? F_ERR6 : F_BYTE;
                        end
                        else
                        begin
                            fstate_next = F_REPLAY;
                        end
                    end
                end
            end
            F_REPLAY:
            begin
                push_valid = 1'b1;
                push_data  = '{op: OP_BYTE, data: bits_reg[idx_reg] ? CH_LF : CH_CR,
                               step_end: 1'b0};
                if (push_ready)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (CNT_W'(idx_reg) + CNT_W'(1) == cnt_reg)
                    begin
                        fstate_next = ovf_reg ? F_ERR6 : F_BYTE;
                    end
                end
            end
            F_ERR6:
            begin
                push_valid = 1'b1;
                push_data  = '{op: OP_ERR6, data: 8'd0, step_end: 1'b0};
                if (push_ready)
                begin
                    fstate_next = F_BYTE;
                end
            end
            F_BYTE:
            begin
                push_valid = 1'b1;
                push_data  = '{op: OP_BYTE, data: byte_reg, step_end: !eol_reg};
                if (push_ready)
                begin
                    cnt_next    = '0;
                    ovf_next    = 1'b0;
                    fstate_next = eol_reg ? F_EOL : F_IDLE;
                end
            end
            F_EOL:
            begin
                push_valid = 1'b1;
                push_data  = '{op: OP_EOL, data: 8'd0, step_end: 1'b1};
                if (push_ready)
                begin
                    fstate_next = F_IDLE;
                end
            end
            default:
            begin
                fstate_next = F_IDLE;
            end
        endcase
    end

    // State and held bytes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fstate_reg <= F_IDLE;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            idx_reg    <= '0;
            eol_reg    <= 1'b0;
        end
        else
        begin
            fstate_reg <= fstate_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            idx_reg    <= idx_next;
            eol_reg    <= eol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        byte_reg <= byte_next;
    end

    `TSRLP_ASSERT_IMPLY(a_replay_in_range, clk, rst_n, fstate_reg == F_REPLAY,
                        CNT_W'(idx_reg) < cnt_reg)
    `TSRLP_ASSERT_IMPLY(a_err6_has_overflow, clk, rst_n, fstate_reg == F_ERR6, ovf_reg)

endmodule

// File: design/tsrlp_back.sv
// Back end: field parser, percent decoder, id check and result staging.
// Depends on tsrlp_pkg for the entry, result types and codes.
`timescale 1ns / 1ps

module tsrlp_back #(
    parameter int ID_WIDTH      = tsrlp_pkg::ID_WIDTH_DEFAULT,
    parameter int MAX_ARGUMENTS = tsrlp_pkg::MAX_ARGUMENTS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    entry_valid,
    output logic                    entry_ready,
    input  tsrlp_pkg::tsrlp_entry_t entry_data,
    output logic                    tok_valid,
    input  logic                    tok_ready,
    output tsrlp_pkg::tsrlp_out_t   tok_data
);
    import tsrlp_pkg::*;

    `include "tab_separated_request_line_parser_unit_macros.svh"

    localparam logic [1:0] PH_ID  = 2'd0;
    localparam logic [1:0] PH_CMD = 2'd1;
    localparam logic [1:0] PH_KEY = 2'd2;
    localparam logic [1:0] PH_VAL = 2'd3;

    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;
    localparam logic [1:0] ESC_SKIP = 2'd3;

    localparam int FLAG_EMPTY_KEY = 0;
    localparam int FLAG_BAD_ENC   = 1;

    typedef struct packed {
        logic [1:0]          phase;
        logic [1:0]          esc;
        logic [3:0]          hn;
        logic [ID_WIDTH-1:0] acc;
        logic                seen;
        logic                bad;
        logic                nonempty;
        logic [7:0]          argc;
        logic [2:0]          err;
        logic [1:0]          flags;
    } parse_state_t;

    typedef enum logic {
        B_RUN,
        B_FLUSH
    } back_state_t;

    back_state_t  bstate_reg, bstate_next;
    parse_state_t st_reg, st_next;
    logic         hold_valid_reg, hold_valid_next;
    tsrlp_out_t   hold_reg, hold_next;
    logic         out_valid_reg, out_valid_next;
    tsrlp_out_t   out_reg, out_next;
    logic         out_free;
    logic         fire;

    logic [ID_WIDTH+3:0] acc_ext;
    logic [ID_WIDTH+3:0] prod;
    logic                prod_ovf;

    // Keep the first error; a break overflow yields to any later error.
    function automatic logic [2:0] merge_err(input logic [2:0] cur, input logic [2:0] code);
        logic [2:0] r;
        r = cur;
        if (code == ST_LONG_BREAK)
        begin
            if (cur == ST_OK)
            begin
                r = ST_LONG_BREAK;
            end
        end
        else if (cur == ST_OK || cur == ST_LONG_BREAK)
        begin
            r = code;
        end
        return r;
    endfunction

    function automatic logic [7:0] next_arg(input logic [7:0] argc);
        return (argc < 8'(MAX_ARGUMENTS)) ? argc + 8'd1 : argc;
    endfunction

    // End of a field: check it and move on to the next one.
    function automatic parse_state_t close_field(input parse_state_t s);
        parse_state_t r;
        logic         bad_enc;
        r       = s;
        bad_enc = s.flags[FLAG_BAD_ENC] || (s.esc != ESC_IDLE);
        unique case (s.phase)
            PH_ID:
            begin
                if (!s.seen || s.bad)
                begin
                    r.err = merge_err(r.err, ST_BAD_ID);
                end
                r.phase = PH_CMD;
            end
            PH_CMD:
            begin
                if (bad_enc || !s.nonempty)
                begin
                    r.err = merge_err(r.err, ST_BAD_CMD);
                end
                r.phase = PH_KEY;
                r.argc  = 8'd1;
            end
            PH_KEY:
            begin
                r.err  = merge_err(r.err, ST_NO_SEP);
                r.argc = next_arg(s.argc);
            end
            default:
            begin
                if (s.flags[FLAG_EMPTY_KEY])
                begin
                    r.err = merge_err(r.err, ST_NO_SEP);
                end
                else if (bad_enc)
                begin
                    r.err = merge_err(r.err, ST_BAD_ENC);
                end
                r.phase = PH_KEY;
                r.argc  = next_arg(s.argc);
            end
        endcase
        r.esc      = ESC_IDLE;
        r.hn       = 4'd0;
        r.nonempty = 1'b0;
        r.flags    = 2'd0;
        return r;
    endfunction

    // Next id value as acc * 10 + digit, with room to see an overflow.
    assign acc_ext  = (ID_WIDTH + 4)'(st_reg.acc);
    assign prod     = (acc_ext << 3) + (acc_ext << 1)
                    + (ID_WIDTH + 4)'(entry_data.data[3:0]);
    assign prod_ovf = (prod[ID_WIDTH+3:ID_WIDTH] != 4'd0);

    assign out_free    = !out_valid_reg || tok_ready;
    assign entry_ready = (bstate_reg == B_RUN) && out_free;
    assign fire        = entry_valid && entry_ready;
    assign tok_valid   = out_valid_reg;
    assign tok_data    = out_reg;

    // Entry processing and result staging.
    always_comb
    begin
        parse_state_t s;
        logic         res_valid;
        tsrlp_out_t   res;
        logic         do_decode;
        logic [4:0]   hx;
        logic [7:0]   c;
        logic [7:0]   dec;
        logic         few;
        logic [2:0]   stc;

        s         = st_reg;
        res_valid = 1'b0;
        res       = '0;
        do_decode = 1'b0;
        dec       = 8'd0;
        few       = 1'b0;
        stc       = ST_OK;
        c         = entry_data.data;
        hx        = hex_nibble(c);

        unique case (entry_data.op)
            OP_BYTE:
            begin
                if (c == CH_TAB)
                begin
                    s = close_field(s);
                end
                else
                begin
                    unique case (s.phase)
                        PH_ID:
                        begin
                            if (c >= CH_ZERO && c <= CH_NINE)
                            begin
                                s.seen = 1'b1;
                                if (!s.bad)
                                begin
                                    if (prod_ovf)
                                    begin
                                        s.bad = 1'b1;
                                    end
                                    else
                                    begin
                                        s.acc = prod[ID_WIDTH-1:0];
                                    end
                                end
                            end
                            else
                            begin
                                s.bad = 1'b1;
                            end
                        end
                        PH_CMD:
                        begin
                            s.nonempty = 1'b1;
                            do_decode  = 1'b1;
                        end
                        PH_KEY:
                        begin
                            if (c == CH_EQ)
                            begin
                                if (s.esc != ESC_IDLE)
                                begin
                                    s.flags[FLAG_BAD_ENC] = 1'b1;
                                end
                                if (!s.nonempty)
                                begin
                                    s.flags[FLAG_EMPTY_KEY] = 1'b1;
                                end
                                s.phase = PH_VAL;
                                s.esc   = ESC_IDLE;
                                s.hn    = 4'd0;
                            end
                            else
                            begin
                                s.nonempty = 1'b1;
                                do_decode  = 1'b1;
                            end
                        end
                        default:
                        begin
                            do_decode = 1'b1;
                        end
                    endcase
                end

                // Percent decoder.
                if (do_decode)
                begin
                    unique case (s.esc)
                        ESC_IDLE:
                        begin
                            if (c == CH_PCT)
                            begin
                                s.esc = ESC_HIGH;
                            end
                            else
                            begin
                                res_valid = 1'b1;
                                dec       = c;
                            end
                        end
                        ESC_HIGH:
                        begin
                            if (hx[4])
                            begin
                                s.hn  = hx[3:0];
                                s.esc = ESC_LOW;
                            end
                            else
                            begin
                                s.flags[FLAG_BAD_ENC] = 1'b1;
                                s.esc = ESC_SKIP;
                            end
                        end
                        ESC_LOW:
                        begin
                            if (hx[4])
                            begin
                                res_valid = 1'b1;
                                dec       = {s.hn, hx[3:0]};
                            end
                            else
                            begin
                                s.flags[FLAG_BAD_ENC] = 1'b1;
                            end
                            s.esc = ESC_IDLE;
                        end
                        default:
                        begin
                            s.esc = ESC_IDLE;
                        end
                    endcase
                end

                if (res_valid)
                begin
                    res.token_kind      = (s.phase == PH_CMD) ? KIND_CMD :
                                          ((s.phase == PH_KEY) ? KIND_KEY : KIND_VAL);
                    res.decoded_byte    = dec;
                    res.argument_number = (s.phase == PH_CMD) ? 8'd0 : s.argc;
                end
            end
            OP_ERR6:
            begin
                s.err = merge_err(s.err, ST_LONG_BREAK);
            end
            OP_EOL:
            begin
                few = (s.phase == PH_ID);
                s   = close_field(s);
                stc = few ? ST_TOO_FEW : s.err;
                res_valid           = 1'b1;
                res.token_kind      = KIND_END;
                res.argument_number = s.argc;
                res.request_id      = (stc == ST_OK) ? 64'(s.acc) : 64'd0;
                res.status          = stc;
                s = '0;
            end
            default:
            begin
                s = st_reg;
            end
        endcase

        bstate_next     = bstate_reg;
        st_next         = st_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !tok_ready;
        out_next        = out_reg;

        // The newest result waits in the hold register until it is known
        // whether it is the last one of its input transfer.
        if (bstate_reg == B_FLUSH)
        begin
            if (out_free)
            begin
                out_valid_next       = 1'b1;
                out_next             = hold_reg;
                out_next.last_result = 1'b1;
                hold_valid_next      = 1'b0;
                bstate_next          = B_RUN;
            end
        end
        else if (fire)
        begin
            st_next = s;
            if (res_valid && hold_valid_reg)
            begin
                out_valid_next       = 1'b1;
                out_next             = hold_reg;
                out_next.last_result = 1'b0;
                hold_next            = res;
                if (entry_data.step_end)
                begin
                    bstate_next = B_FLUSH;
                end
            end
            else if (res_valid)
            begin
                if (entry_data.step_end)
                begin
                    out_valid_next       = 1'b1;
                    out_next             = res;
                    out_next.last_result = 1'b1;
                end
                else
                begin
                    hold_next       = res;
                    hold_valid_next = 1'b1;
                end
            end
            else if (hold_valid_reg && entry_data.step_end)
            begin
                out_valid_next       = 1'b1;
                out_next             = hold_reg;
                out_next.last_result = 1'b1;
                hold_valid_next      = 1'b0;
            end
        end
    end

    // Parser state, staging state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg     <= B_RUN;
            st_reg         <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bstate_reg     <= bstate_next;
            st_reg         <= st_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    `TSRLP_ASSERT_IMPLY(a_flush_has_hold, clk, rst_n, bstate_reg == B_FLUSH, hold_valid_reg)
    `TSRLP_ASSERT_NEXT(a_eol_restarts, clk, rst_n, fire && entry_data.op == OP_EOL,
                       st_reg.phase == PH_ID && st_reg.err == ST_OK)

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the tab separated request line parser.
// Depends on tsrlp_pkg and tab_separated_request_line_parser_unit; a built-in
// line predictor checks every token and end status the block returns.
`timescale 1ns / 1ps

module tb_top;
    import tsrlp_pkg::*;

    localparam int ID_BITS      = ID_WIDTH_DEFAULT;
    localparam int HELD_MAX     = PENDING_BREAKS_DEFAULT;
    localparam int ARG_LIMIT    = MAX_ARGUMENTS_DEFAULT;
    // Random bytes; with the directed rows and the long argument line the
    // whole run sends about 400 transfers.
    localparam int RANDOM_ITEMS = 120;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;
    localparam logic [63:0] ID_MAX = {64{1'b1}} >> (64 - ID_BITS);

    // Where the predictor stands within the line.
    typedef enum logic [1:0] {FLD_ID, FLD_CMD, FLD_KEY, FLD_VAL} field_t;

    // Progress through a percent escape.
    typedef enum logic [1:0] {ESC_NONE, ESC_HIGH, ESC_LOW, ESC_SKIP} escape_t;

    // Kinds of damage the random line builder can apply.
    typedef enum int unsigned {
        FLAW_NONE, FLAW_ID_CHAR, FLAW_ID_EMPTY, FLAW_ID_BIG, FLAW_CMD_EMPTY,
        FLAW_NO_EQ, FLAW_KEY_EMPTY, FLAW_ESCAPE, FLAW_BREAK_RUN, FLAW_NO_TAB, FLAW_NOISE
    } flaw_t;

    // One directed transfer; the end status is typed in where the row ends a line.
    typedef struct packed {
        logic [7:0]  line_byte;
        logic        end_of_line;
        logic        typed;
        logic [7:0]  end_args;
        logic [63:0] end_id;
        logic [2:0]  end_status;
    } directed_row_t;

    localparam directed_row_t DIRECTED_ROWS [22] = '{
        // A lone top byte with no tab at all.
        '{8'hFF, 1'b1, 1'b1, 8'd0, 64'd0, ST_TOO_FEW},
        // Escaped command, key, value holding '=' and a zero byte, trailing CR.
        '{"1",    1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{CH_TAB, 1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{CH_PCT, 1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{"4",    1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{"1",    1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{CH_TAB, 1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{"a",    1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{CH_EQ,  1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{CH_EQ,  1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{8'h00,  1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{CH_CR,  1'b1, 1'b1, 8'd2, 64'd1, ST_OK},
        // A tab alone: empty id.
        '{CH_TAB, 1'b1, 1'b1, 8'd1, 64'd0, ST_BAD_ID},
        // Five CRs inside the command, then a plain byte.
        '{"2",    1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{CH_TAB, 1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{"c",    1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{CH_CR,  1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{CH_CR,  1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{CH_CR,  1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{CH_CR,  1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{CH_CR,  1'b0, 1'b0, 8'd0, 64'd0, ST_OK},
        '{"x",    1'b1, 1'b1, 8'd1, 64'd0, ST_LONG_BREAK}
    };

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    tsrlp_in_t   req_data  = '0;
    logic        tok_valid;
    logic        tok_ready = 1'b0;
    tsrlp_out_t  tok_data;

    tsrlp_out_t  expected_tokens [$];
    logic [7:0]  line_buf [$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    bit          calm_send      = 1'b0;
    bit          calm_recv      = 1'b0;

    // Predictor state for the line in progress.
    field_t      cur_field;
    escape_t     esc_step;
    logic [3:0]  esc_high;
    logic [63:0] id_value;
    logic        id_has_digit;
    logic        id_invalid;
    logic        field_used;
    logic [7:0]  arg_index;
    bit          held_is_lf [HELD_MAX];
    int unsigned held_count;
    logic [2:0]  line_error;
    logic        key_empty;
    logic        enc_bad;

    tab_separated_request_line_parser_unit #(
        .ID_WIDTH       (ID_BITS),
        .PENDING_BREAKS (HELD_MAX),
        .MAX_ARGUMENTS  (ARG_LIMIT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_data  (tok_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------

    function automatic void clear_line_state();
        cur_field    = FLD_ID;
        esc_step     = ESC_NONE;
        esc_high     = 4'd0;
        id_value     = 64'd0;
        id_has_digit = 1'b0;
        id_invalid   = 1'b0;
        field_used   = 1'b0;
        arg_index    = 8'd0;
        held_count   = 0;
        line_error   = ST_OK;
        key_empty    = 1'b0;
        enc_bad      = 1'b0;
        foreach (held_is_lf[i])
            held_is_lf[i] = 1'b0;
    endfunction

    // A long break run only sticks when nothing else has failed; any later
    // field error replaces it.
    function automatic void note_error(input logic [2:0] code);
        if (code == ST_LONG_BREAK)
        begin
            if (line_error == ST_OK)
                line_error = code;
        end
        else if (line_error == ST_OK || line_error == ST_LONG_BREAK)
        begin
            line_error = code;
        end
    endfunction

    function automatic void push_result(input logic [1:0] kind, input logic [7:0] data,
                                        input logic [7:0] arg, input logic [63:0] id,
                                        input logic [2:0] st);
        tsrlp_out_t r;
        r.token_kind      = kind;
        r.decoded_byte    = data;
        r.argument_number = arg;
        r.request_id      = id;
        r.status          = st;
        r.last_result     = 1'b0;
        expected_tokens.insert(expected_tokens.size(), r);
    endfunction

    function automatic int nibble_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void emit_decoded(input logic [7:0] c);
        logic [1:0] kind;
        kind = (cur_field == FLD_CMD) ? KIND_CMD : ((cur_field == FLD_KEY) ? KIND_KEY : KIND_VAL);
        push_result(kind, c, (cur_field == FLD_CMD) ? 8'd0 : arg_index, 64'd0, ST_OK);
    endfunction

    // Percent decoding; a bad high digit also swallows the byte after it.
    function automatic void decode_char(input logic [7:0] c);
        int h;
        h = nibble_value(c);
        case (esc_step)
            ESC_NONE:
            begin
                if (c == CH_PCT)
                    esc_step = ESC_HIGH;
                else
                    emit_decoded(c);
            end
            ESC_HIGH:
            begin
                if (h >= 0)
                begin
                    esc_high = 4'(h);
                    esc_step = ESC_LOW;
                end
                else
                begin
                    enc_bad  = 1'b1;
                    esc_step = ESC_SKIP;
                end
            end
            ESC_LOW:
            begin
                if (h >= 0)
                    emit_decoded({esc_high, 4'(h)});
                else
                    enc_bad = 1'b1;
                esc_step = ESC_NONE;
            end
            default:
                esc_step = ESC_NONE;
        endcase
    endfunction

    function automatic void bump_argument();
        if (arg_index < ARG_LIMIT)
            arg_index++;
    endfunction

    function automatic void close_field();
        case (cur_field)
            FLD_ID:
            begin
                if (!id_has_digit || id_invalid)
                    note_error(ST_BAD_ID);
                cur_field = FLD_CMD;
            end
            FLD_CMD:
            begin
                if (esc_step != ESC_NONE)
                    enc_bad = 1'b1;
                if (enc_bad || !field_used)
                    note_error(ST_BAD_CMD);
                cur_field = FLD_KEY;
                arg_index = 8'd1;
            end
            FLD_KEY:
            begin
                note_error(ST_NO_SEP);
                bump_argument();
            end
            default:
            begin
                if (esc_step != ESC_NONE)
                    enc_bad = 1'b1;
                if (key_empty)
                    note_error(ST_NO_SEP);
                else if (enc_bad)
                    note_error(ST_BAD_ENC);
                cur_field = FLD_KEY;
                bump_argument();
            end
        endcase
        esc_step   = ESC_NONE;
        esc_high   = 4'd0;
        field_used = 1'b0;
        key_empty  = 1'b0;
        enc_bad    = 1'b0;
    endfunction

    function automatic void parse_line_byte(input logic [7:0] c);
        logic [63:0] digit;
        if (c == CH_TAB)
        begin
            close_field();
            return;
        end
        case (cur_field)
            FLD_ID:
            begin
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    digit        = 64'(c - CH_ZERO);
                    id_has_digit = 1'b1;
                    if (!id_invalid)
                    begin
                        if (id_value > (ID_MAX - digit) / 64'd10)
                            id_invalid = 1'b1;
                        else
                            id_value = id_value * 64'd10 + digit;
                    end
                end
                else
                begin
                    id_invalid = 1'b1;
                end
            end
            FLD_CMD:
            begin
                field_used = 1'b1;
                decode_char(c);
            end
            FLD_KEY:
            begin
                if (c == CH_EQ)
                begin
                    if (esc_step != ESC_NONE)
                        enc_bad = 1'b1;
                    if (!field_used)
                        key_empty = 1'b1;
                    cur_field = FLD_VAL;
                    esc_step  = ESC_NONE;
                    esc_high  = 4'd0;
                end
                else
                begin
                    field_used = 1'b1;
                    decode_char(c);
                end
            end
            default:
                decode_char(c);
        endcase
    endfunction

    // Works out every result that one accepted transfer causes.
    function automatic void predict_step(input logic [7:0] b, input logic eol);
        logic        is_break;
        logic        few;
        logic [2:0]  st;
        int unsigned replay;
        int unsigned queued_earlier;
        tsrlp_out_t  tail;
        queued_earlier = expected_tokens.size();
        is_break       = (b == CH_CR || b == CH_LF);

        // CR/LF bytes are held until a byte other than CR or LF or the line end shows up.
        if (is_break && !eol)
        begin
            if (held_count < HELD_MAX)
            begin
                held_is_lf[held_count] = (b == CH_LF);
                held_count++;
            end
            else
            begin
                held_count = HELD_MAX + 1;
            end
            return;
        end

        if (!is_break)
        begin
            replay = (held_count > HELD_MAX) ? HELD_MAX : held_count;
            for (int unsigned i = 0; i < replay; i++)
                parse_line_byte(held_is_lf[i] ? CH_LF : CH_CR);
            if (held_count > HELD_MAX)
                note_error(ST_LONG_BREAK);
            parse_line_byte(b);
        end
        held_count = 0;

        if (eol)
        begin
            few = (cur_field == FLD_ID);
            close_field();
            st = few ? ST_TOO_FEW : line_error;
            push_result(KIND_END, 8'h00, arg_index, (st == ST_OK) ? id_value : 64'd0, st);
            clear_line_state();
        end

        if (expected_tokens.size() > queued_earlier)
        begin
            tail = expected_tokens.pop_back();
            tail.last_result = 1'b1;
            expected_tokens.insert(expected_tokens.size(), tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Random line builder
    // ------------------------------------------------------------------

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 60);
    endfunction

    function automatic logic [7:0] hex_char(input int unsigned n);
        if (n < 10)
            return CH_ZERO + 8'(n);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n - 10);
    endfunction

    // An ordinary byte of a field: never a tab, percent, CR or LF; no '=' in keys.
    function automatic logic [7:0] plain_char(input bit for_key);
        logic [7:0] c;
        do
        begin
            if ($urandom_range(0, 3) == 0)
                c = 8'($urandom_range(0, 255));
            else
                c = 8'($urandom_range(8'h61, 8'h7A));
        end
        while (c == CH_TAB || c == CH_PCT || c == CH_CR || c == CH_LF
               || (for_key && c == CH_EQ));
        return c;
    endfunction

    // Appends one byte to the line under construction.
    function automatic void add_byte(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endfunction

    function automatic void add_string(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic void add_breaks(input int unsigned n);
        repeat (n)
            add_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
    endfunction

    function automatic void add_id();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 8)
        begin
            add_string("18446744073709551615");
        end
        else if (r == 9)
        begin
            // Twenty digits sit right around the top of the id range.
            add_byte("1");
            repeat (19)
                add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    // Field text with escapes and short CR/LF runs mixed in.
    function automatic void add_text(input bit for_key, input int unsigned len);
        int unsigned r;
        logic [7:0]  v;
        repeat (len)
        begin
            r = $urandom_range(0, 19);
            if (r < 3)
            begin
                v = 8'($urandom_range(0, 255));
                add_byte(CH_PCT);
                add_byte(hex_char(v[7:4]));
                add_byte(hex_char(v[3:0]));
            end
            else if (r == 3 && !for_key)
            begin
                add_byte(CH_EQ);
            end
            else if (r == 4)
            begin
                add_breaks($urandom_range(1, HELD_MAX));
            end
            else
            begin
                add_byte(plain_char(for_key));
            end
        end
    endfunction

    // Damage appended to the end of a command or value.
    function automatic void add_flaw_text(input flaw_t flaw);
        if (flaw == FLAW_ESCAPE)
        begin
            add_byte(CH_PCT);
            case ($urandom_range(0, 2))
                0:
                begin
                    add_byte(8'($urandom_range(8'h67, 8'h7A)));
                    add_byte(plain_char(1'b1));
                end
                1:
                    add_byte(hex_char($urandom_range(0, 15)));
                default:
                    ;
            endcase
        end
        else if (flaw == FLAW_BREAK_RUN)
        begin
            add_breaks($urandom_range(HELD_MAX + 1, HELD_MAX + 5));
            add_byte(plain_char(1'b1));
        end
    endfunction

    function automatic void build_line(input flaw_t flaw);
        int unsigned nargs;
        int unsigned target;
        line_buf.delete();

        if (flaw == FLAW_NOISE)
        begin
            repeat ($urandom_range(1, 12))
                add_byte(8'($urandom_range(0, 255)));
            return;
        end
        if (flaw == FLAW_NO_TAB)
        begin
            repeat ($urandom_range(1, 8))
                add_byte($urandom_range(0, 1) ? CH_ZERO + 8'($urandom_range(0, 9))
                                              : plain_char(1'b0));
            return;
        end

        // Id field.
        if (flaw == FLAW_ID_BIG)
            add_string($urandom_range(0, 1) ? "18446744073709551616" : "99999999999999999999");
        else if (flaw != FLAW_ID_EMPTY)
            add_id();
        if (flaw == FLAW_ID_CHAR)
            add_byte(8'($urandom_range(8'h3A, 8'hFF)));

        // Command, then key=value arguments.
        nargs = $urandom_range(0, 4);
        if ((flaw == FLAW_NO_EQ || flaw == FLAW_KEY_EMPTY) && nargs == 0)
            nargs = 1;
        target = (nargs == 0 || $urandom_range(0, 1) == 0) ? 0 : nargs;
        add_byte(CH_TAB);
        if (flaw != FLAW_CMD_EMPTY)
            add_text(1'b0, $urandom_range(1, 5));
        if (target == 0)
            add_flaw_text(flaw);
        for (int unsigned a = 1; a <= nargs; a++)
        begin
            add_byte(CH_TAB);
            if (!(a == nargs && flaw == FLAW_KEY_EMPTY))
                add_text(1'b1, $urandom_range(1, 4));
            if (!(a == nargs && flaw == FLAW_NO_EQ))
            begin
                add_byte(CH_EQ);
                add_text(1'b0, $urandom_range(0, 5));
                if (a == target)
                    add_flaw_text(flaw);
            end
        end

        // Sometimes a trailing CR/LF run or a dangling tab.
        if ($urandom_range(0, 4) == 0)
            add_breaks($urandom_range(1, HELD_MAX + 2));
        else if ($urandom_range(0, 19) == 0)
            add_byte(CH_TAB);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Sends one byte and predicts its results at the transfer edge.
    task automatic send_item(input logic [7:0] b, input logic eol);
        int unsigned gap;
        gap = pick_gap(calm_send);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= '{line_byte: b, end_of_line: eol};
        do
            @(posedge clk);
        while (!req_ready);
        predict_step(b, eol);
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_item(line_buf[i], i == line_buf.size() - 1);
    endtask

    // Holds the request side idle until every expected result has come back.
    task automatic wait_until_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        tsrlp_out_t  typed_end;
        flaw_t       flaw;
        int unsigned r;
        int unsigned random_items;
        clear_line_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; a typed row replaces the predicted end status.
        foreach (DIRECTED_ROWS[i])
        begin
            send_item(DIRECTED_ROWS[i].line_byte, DIRECTED_ROWS[i].end_of_line);
            if (DIRECTED_ROWS[i].typed)
            begin
                void'(expected_tokens.pop_back());
                typed_end.token_kind      = KIND_END;
                typed_end.decoded_byte    = 8'h00;
                typed_end.argument_number = DIRECTED_ROWS[i].end_args;
                typed_end.request_id      = DIRECTED_ROWS[i].end_id;
                typed_end.status          = DIRECTED_ROWS[i].end_status;
                typed_end.last_result     = 1'b1;
                expected_tokens.insert(expected_tokens.size(), typed_end);
            end
            if (DIRECTED_ROWS[i].end_of_line)
                wait_until_drained();
        end

        // One line with more arguments than the argument number can count.
        line_buf.delete();
        add_string("1");
        add_byte(CH_TAB);
        add_string("c");
        repeat (ARG_LIMIT + 2)
            add_byte(CH_TAB);
        add_string("k=v");
        send_line();

        // Random lines: mostly well formed, some damaged, a few pure noise.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            calm_send = ($urandom_range(0, 4) == 0);
            calm_recv = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 55)
                flaw = FLAW_NONE;
            else if (r < 85)
                flaw = flaw_t'($urandom_range(FLAW_ID_CHAR, FLAW_BREAK_RUN));
            else if (r < 93)
                flaw = FLAW_NO_TAB;
            else
                flaw = FLAW_NOISE;
            build_line(flaw);
            send_line();
            random_items += line_buf.size();
            if ($urandom_range(0, 6) == 0)
                wait_until_drained();
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_tokens.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Token side
    // ------------------------------------------------------------------

    // Ready runs and stalls, both of random length.
    initial
    begin : token_sink
        int unsigned stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = pick_gap(calm_recv);
            if (stall != 0)
            begin
                tok_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            tok_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Compares each token transfer with the oldest expectation.
    initial
    begin : token_checker
        tsrlp_out_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (tok_valid && tok_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (tok_valid && tok_ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected token: kind %0d byte %02h arg %0d id %0d st %0d last %0d",
                                 tok_data.token_kind, tok_data.decoded_byte,
                                 tok_data.argument_number, tok_data.request_id,
                                 tok_data.status, tok_data.last_result);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (tok_data.token_kind !== want.token_kind
                        || tok_data.decoded_byte !== want.decoded_byte
                        || tok_data.argument_number !== want.argument_number
                        || tok_data.request_id !== want.request_id
                        || tok_data.status !== want.status
                        || tok_data.last_result !== want.last_result)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                        begin
                            $display("token mismatch at %0t", $realtime);
                            $display("  expected kind %0d byte %02h arg %0d id %0d st %0d last %0d",
                                     want.token_kind, want.decoded_byte, want.argument_number,
                                     want.request_id, want.status, want.last_result);
                            $display("  actual   kind %0d byte %02h arg %0d id %0d st %0d last %0d",
                                     tok_data.token_kind, tok_data.decoded_byte,
                                     tok_data.argument_number, tok_data.request_id,
                                     tok_data.status, tok_data.last_result);
                        end
                    end
                end
            end
        end
    end

    // Ends the run when no transfer happens on either side for too long.
    initial
    begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/tsrlp_pkg.sv
design/tsrlp_queue.sv
design/tsrlp_front.sv
design/tsrlp_back.sv
design/tab_separated_request_line_parser_unit.sv
tb/sv/tb_top.sv
